[sv/qte_pkg.sv]
// Package for the quaternion to Euler angle converter: CORDIC table and widths.
`timescale 1ns / 1ps
package qte_pkg;
    localparam int STEPS = 24;
    localparam int CW = 40;
    localparam int SQW = 31;
    localparam logic [31:0] ATAN_TAB [STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        logic                 zero;
        logic [31:0]          zval;
    } cordic_t;

    function automatic cordic_t cordic_init(input logic signed [17:0] y,
                                            input logic signed [17:0] x);
        cordic_t c;
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ye;
        xe = CW'(x);
        ye = CW'(y);
        c.zero = (y == 18'sd0);
        c.zval = (x < 0) ? 32'h8000_0000 : 32'h0;
        if (x < 0) begin
            xe = -xe;
            ye = -ye;
            c.z = 32'h8000_0000;
        end else begin
            c.z = 32'h0;
        end
        c.x = xe <<< 12;
        c.y = ye <<< 12;
        return c;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        cordic_t r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        r = c;
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (c.y > 0) begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + ATAN_TAB[i];
        end else begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - ATAN_TAB[i];
        end
        return r;
    endfunction

    function automatic logic [31:0] cordic_out(input cordic_t c);
        return c.zero ? c.zval : c.z;
    endfunction

    function automatic logic signed [17:0] to_q215(input logic signed [33:0] t);
        logic signed [33:0] r;
        r = (t + 34'sd16384) >>> 15;
        if (r > 34'sd131071) begin
            return 18'sd131071;
        end else if (r < -34'sd131072) begin
            return -18'sd131072;
        end
        return r[17:0];
    endfunction
endpackage

[sv/quaternion_to_euler_angles.sv]
// Pipelined quaternion to ZYX Euler angle converter.
`timescale 1ns / 1ps
// Pipeline: 3 product/term stages, 16 square-root stages, 24 CORDIC stages and
// 3 output stages, from input request to result. Throughput: one
// request per cycle, set by a fully pipelined datapath; stalls hold all stages.
// Reset: aresetn clears all stage valid bits; data registers are not reset.
module quaternion_to_euler_angles (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);
    localparam int ST = qte_pkg::STEPS;
    localparam int SQ = 16;
    localparam int NS = 3 + SQ + ST + 3;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic          adv;
    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS-1];

    always_comb begin
        vld_next = {vld_reg[NS-2:0], s_tvalid};
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: products
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [31:0] wz_reg, xy_reg, zz_reg;
    logic signed [15:0] qx, qy, qz, qw;
    assign qx = s_tdata[15:0];
    assign qy = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];
    always_ff @(posedge aclk) begin
        if (adv) begin
            wx_reg <= qw * qx; yz_reg <= qy * qz; xx_reg <= qx * qx;
            yy_reg <= qy * qy; wy_reg <= qw * qy; zx_reg <= qz * qx;
            wz_reg <= qw * qz; xy_reg <= qx * qy; zz_reg <= qz * qz;
        end
    end

    // Stage 2: terms
    logic signed [17:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    localparam logic signed [33:0] ONE = 34'sd1 <<< 30;
    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg <= qte_pkg::to_q215(34'sd2 * (34'(wx_reg) + 34'(yz_reg)));
            t1_reg <= qte_pkg::to_q215(ONE - 34'sd2 * (34'(xx_reg) + 34'(yy_reg)));
            t2_reg <= qte_pkg::to_q215(34'sd2 * (34'(wy_reg) - 34'(zx_reg)));
            t3_reg <= qte_pkg::to_q215(34'sd2 * (34'(wz_reg) + 34'(xy_reg)));
            t4_reg <= qte_pkg::to_q215(ONE - 34'sd2 * (34'(yy_reg) + 34'(zz_reg)));
        end
    end

    // Stage 3: pitch radicand and clamp flags
    logic [30:0]        rad_reg;
    logic signed [17:0] p_t_reg;
    logic               p_hi_reg, p_lo_reg;
    logic signed [17:0] r_y3_reg, r_x3_reg, y_y3_reg, y_x3_reg;
    logic signed [35:0] t2sq;
    assign t2sq = t2_reg * t2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg  <= 31'((36'sd1 <<< 30) - t2sq);
            p_t_reg  <= t2_reg;
            p_hi_reg <= t2_reg >= 18'sd32768;
            p_lo_reg <= t2_reg <= -18'sd32768;
            r_y3_reg <= t0_reg; r_x3_reg <= t1_reg;
            y_y3_reg <= t3_reg; y_x3_reg <= t4_reg;
        end
    end

    // Square root: one result bit per stage
    typedef struct packed {
        logic [31:0]        rem;
        logic [15:0]        root;
        logic [30:0]        v;
        logic signed [17:0] pt;
        logic               hi;
        logic               lo;
        logic signed [17:0] ry, rx, yy, yx;
    } sq_t;
    sq_t sq_reg [SQ+1];
    always_comb begin
        sq_reg[0] = '0;
        sq_reg[0].v  = rad_reg;
        sq_reg[0].pt = p_t_reg;
        sq_reg[0].hi = p_hi_reg;
        sq_reg[0].lo = p_lo_reg;
        sq_reg[0].ry = r_y3_reg; sq_reg[0].rx = r_x3_reg;
        sq_reg[0].yy = y_y3_reg; sq_reg[0].yx = y_x3_reg;
    end
    for (genvar k = 0; k < SQ; k++) begin : g_sq
        sq_t nx;
        logic [31:0] rr;
        logic [31:0] tr;
        always_comb begin
            nx = sq_reg[k];
            rr = {sq_reg[k].rem[29:0], 2'(32'(sq_reg[k].v) >> (30 - 2 * k))};
            tr = {14'd0, sq_reg[k].root, 2'b01};
            if (rr >= tr) begin
                nx.rem  = rr - tr;
                nx.root = {sq_reg[k].root[14:0], 1'b1};
            end else begin
                nx.rem  = rr;
                nx.root = {sq_reg[k].root[14:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[k+1] <= nx;
            end
        end
    end

    // CORDIC: three lanes in lockstep
    typedef struct packed {
        qte_pkg::cordic_t r;
        qte_pkg::cordic_t p;
        qte_pkg::cordic_t y;
        logic             hi;
        logic             lo;
    } cl_t;
    cl_t cl_reg [ST+1];
    always_comb begin
        cl_reg[0].r  = qte_pkg::cordic_init(sq_reg[SQ].ry, sq_reg[SQ].rx);
        cl_reg[0].p  = qte_pkg::cordic_init(sq_reg[SQ].pt,
                                            {2'b00, sq_reg[SQ].root});
        cl_reg[0].y  = qte_pkg::cordic_init(sq_reg[SQ].yy, sq_reg[SQ].yx);
        cl_reg[0].hi = sq_reg[SQ].hi;
        cl_reg[0].lo = sq_reg[SQ].lo;
    end
    for (genvar k = 0; k < ST; k++) begin : g_cd
        always_ff @(posedge aclk) begin
            if (adv) begin
                cl_reg[k+1].r  <= qte_pkg::cordic_step(cl_reg[k].r, k);
                cl_reg[k+1].p  <= qte_pkg::cordic_step(cl_reg[k].p, k);
                cl_reg[k+1].y  <= qte_pkg::cordic_step(cl_reg[k].y, k);
                cl_reg[k+1].hi <= cl_reg[k].hi;
                cl_reg[k+1].lo <= cl_reg[k].lo;
            end
        end
    end

    // Output stages
    logic [31:0] ra_reg, pa_reg, ya_reg;
    logic [31:0] rb_reg, pb_reg, yb_reg;
    logic [47:0] out_reg;
    logic [31:0] rb_s, pb_s, yb_s;
    assign rb_s = rb_reg + 32'h8000;
    assign pb_s = pb_reg + 32'h8000;
    assign yb_s = yb_reg + 32'h8000;
    always_ff @(posedge aclk) begin
        if (adv) begin
            ra_reg <= qte_pkg::cordic_out(cl_reg[ST].r);
            ya_reg <= qte_pkg::cordic_out(cl_reg[ST].y);
            if (cl_reg[ST].hi) begin
                pa_reg <= 32'h4000_0000;
            end else if (cl_reg[ST].lo) begin
                pa_reg <= 32'hC000_0000;
            end else begin
                pa_reg <= qte_pkg::cordic_out(cl_reg[ST].p);
            end
            rb_reg  <= ra_reg;
            pb_reg  <= 32'h0 - pa_reg;
            yb_reg  <= ya_reg;
            out_reg <= {yb_s[31:16], pb_s[31:16], rb_s[31:16]};
        end
    end
    assign m_tdata = out_reg;
endmodule

[tb/tb_top.sv]
// Testbench for the quaternion to Euler angle converter, checked by a built-in predictor.
`timescale 1ns / 1ps
module tb_top;
    localparam int LATENCY = 46;
    localparam int HOLD_OFF = 300;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [31:0] ATAN_STEP [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;

    euler_t expected_angles[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     requests_sent = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_req = 0;
    int     hold_off_taken = 0;
    int     hold_off_cycles = 0;
    longint cycles = 0;

    quaternion_to_euler_angles dut (.*);

    always #2 aclk = ~aclk;

    function automatic longint round_q215(longint t);
        longint r;
        r = (t + 16384) >>> 15;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r;
    endfunction

    function automatic logic [31:0] vector_angle(longint yv, longint xv);
        logic [31:0] acc;
        longint xs, ys;
        acc = 0;
        if (yv == 0) return (xv < 0) ? 32'h8000_0000 : 32'h0;
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            acc = 32'h8000_0000;
        end
        xv = xv * 4096;
        yv = yv * 4096;
        for (int i = 0; i < 24; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0) begin
                xv = xv + ys; yv = yv - xs; acc = acc + ATAN_STEP[i];
            end else begin
                xv = xv - ys; yv = yv + xs; acc = acc - ATAN_STEP[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] to_bam16(logic [31:0] a);
        logic [31:0] s;
        s = a + 32'h8000;
        return s[31:16];
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) r = r + (64'sd1 <<< b);
        return r;
    endfunction

    function automatic euler_t euler_of(quat_t q);
        longint x, y, z, w, one, t0, t1, t2, t3, t4;
        logic [31:0] pa;
        euler_t e;
        x = q.x; y = q.y; z = q.z; w = q.w;
        one = 64'sd1 <<< 30;
        t0 = round_q215(2 * (w * x + y * z));
        t1 = round_q215(one - 2 * (x * x + y * y));
        t2 = round_q215(2 * (w * y - z * x));
        t3 = round_q215(2 * (w * z + x * y));
        t4 = round_q215(one - 2 * (y * y + z * z));
        if (t2 >= 32768) pa = 32'h4000_0000;
        else if (t2 <= -32768) pa = 32'hC000_0000;
        else pa = vector_angle(t2, floor_sqrt(one - t2 * t2));
        e.roll = to_bam16(vector_angle(t0, t1));
        e.pitch = to_bam16(32'h0 - pa);
        e.yaw = to_bam16(vector_angle(t3, t4));
        return e;
    endfunction

    // called at a falling edge; valid stays high between back-to-back requests
    task automatic send_quat(quat_t q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tdata <= q;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        expected_angles.push_back(euler_of(q));
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (expected_angles.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_comp;
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    // unit quaternion with random direction, so terms stay in range
    function automatic quat_t rand_unit;
        real a, b, c, d, n;
        quat_t q;
        a = $itor($signed($urandom_range(2000)) - 1000);
        b = $itor($signed($urandom_range(2000)) - 1000);
        c = $itor($signed($urandom_range(2000)) - 1000);
        d = $itor($signed($urandom_range(2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        q.x = 16'($rtoi(a / n * 32767.0));
        q.y = 16'($rtoi(b / n * 32767.0));
        q.z = 16'($rtoi(c / n * 32767.0));
        q.w = 16'($rtoi(d / n * 32767.0));
        return q;
    endfunction

    task automatic test_directed;
        quat_t q;
        logic [15:0] v [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h5A82, 16'hA57E, 16'hFFFF};
        send_quat('{w: 16'h7FFF, z: 0, y: 0, x: 0});
        send_quat('{w: 16'h8000, z: 0, y: 0, x: 0});
        send_quat('{w: 0, z: 0, y: 0, x: 0});
        send_quat('{w: 0, z: 0, y: 0, x: 16'h7FFF});  // roll at pi
        send_quat('{w: 0, z: 16'h7FFF, y: 0, x: 0});  // yaw at pi
        send_quat('{w: 16'h5A82, z: 0, y: 16'h5A82, x: 0});  // gimbal lock
        send_quat('{w: 16'h5A82, z: 0, y: 16'hA57E, x: 0});
        send_quat('{w: 16'h7FFF, z: 16'h7FFF, y: 16'h7FFF, x: 16'h7FFF});
        send_quat('{w: 16'h8000, z: 16'h8000, y: 16'h8000, x: 16'h8000});
        send_quat('{w: 16'h7FFF, z: 16'h8000, y: 16'h7FFF, x: 16'h8000});
        for (int i = 0; i < 12; i++) begin
            q.x = v[i % 6]; q.y = v[(i + 1) % 6]; q.z = v[(i + 3) % 6]; q.w = v[(i * 5) % 6];
            send_quat(q);
        end
        drain();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        quat_t q;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) begin
                q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
            end else begin
                q = rand_unit();
            end
            send_quat(q);
        end
        drain();
    endtask

    task automatic test_back_pressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req++;
        for (int i = 0; i < 120; i++) send_quat(rand_unit());
        drain();
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off when one is requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_off_req != hold_off_taken) begin
            hold_off_taken <= hold_off_req;
            hold_off_cycles <= HOLD_OFF;
            m_tready <= 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        euler_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_angles.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("request %0d: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                                 results_seen, want.roll, got.roll, want.pitch, got.pitch,
                                 want.yaw, got.yaw);
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        test_directed();
        test_random(250, 0, 0);
        test_random(250, 50, 0);
        test_random(250, 0, 50);
        test_random(180, 7, 7);
        test_back_pressure();
        repeat (LATENCY + 20) @(posedge aclk);
        if (expected_angles.size() != 0) begin
            mismatches += expected_angles.size();
            $display("%0d results missing", expected_angles.size());
        end
        $display("%0d requests, %0d results; directed extremes, unit and raw random quats,",
                 requests_sent, results_seen);
        $display("idle/stall phases and a long output hold-off; %0d mismatches", mismatches);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

[files.f]
sv/qte_pkg.sv
sv/quaternion_to_euler_angles.sv
tb/tb_top.sv
